// ----- src/rfom_pkg.sv -----
// rfom_pkg: shared types and codes for the ring fifo with overflow modes
// no dependencies; imported by ring_fifo_overflow_modes, rfom_ctrl and rfom_datapath
package rfom_pkg;

  // input actions
  localparam logic [1:0] ACT_OPEN = 2'd0;
  localparam logic [1:0] ACT_DATA = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // overflow modes
  localparam logic [1:0] MODE_BLOCK = 2'd0;
  localparam logic [1:0] MODE_SKIP  = 2'd1;
  localparam logic [1:0] MODE_TRIM  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_RETRY    = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] message_length;
    logic [7:0]  data_byte;
  } rfom_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_byte;
    logic [9:0]  free_space;
    logic [15:0] accepted_count;
    logic        message_done;
  } rfom_out_t;

  // controller to datapath
  typedef struct packed {
    logic step;       // input beat taken this cycle
    logic load_read;  // registered ram data is valid, fold it into the result
  } rfom_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic read_hit;   // current input is a read of a non-empty buffer
  } rfom_sts_t;

endpackage

// ----- src/ring_fifo_overflow_modes.sv -----
// ring_fifo_overflow_modes: byte ring fifo keeping one slot empty, three overflow modes
// result registered in the cycle after its beat; a byte read first waits in S_RD
// throughput: one beat per cycle unless out_ready stalls; a byte read holds off input
// reset: synchronous active low; clears offsets, message state, result valid, mode to skip
// the byte store is not cleared: only written slots ever lie between the offsets
// depends on rfom_pkg, rfom_ctrl, rfom_datapath, rfom_ram
module ring_fifo_overflow_modes import rfom_pkg::*; #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst_n,

  // configuration: transfer mode register
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,

  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  rfom_in_t   in_data,

  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output rfom_out_t  out_data
);

  // command and status between controller and datapath
  rfom_cmd_t cmd;
  rfom_sts_t sts;

  // controller: takes a beat when the result register is free or draining,
  // holds off input while a store read is in flight
  rfom_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: offsets, message admission, byte store and the result register
  rfom_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

endmodule

// ----- src/rfom_ram.sv -----
// rfom_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module rfom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/rfom_datapath.sv -----
// rfom_datapath: offsets, message tracking, mode register, byte store and result register
// depends on rfom_pkg and rfom_ram
module rfom_datapath import rfom_pkg::*; #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  rfom_in_t   in_data,
  input  rfom_cmd_t  cmd,
  output rfom_sts_t  sts,
  output rfom_out_t  out_data
);

  localparam int OW = $clog2(BUFFER_DEPTH);
  localparam int FW = OW + 1;
  localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);
  localparam logic [OW-1:0] LAST_OFF = OW'(BUFFER_DEPTH - 1);

  logic [1:0]    mode_r;
  logic [OW-1:0] wr_off_r, wr_off_nxt;
  logic [OW-1:0] rd_off_r, rd_off_nxt;
  logic          admitted_r, admitted_nxt;
  logic          trim_drop_r, trim_drop_nxt;
  logic [15:0]   remaining_r, remaining_nxt;
  logic [15:0]   accepted_r, accepted_nxt;
  rfom_out_t     out_r, out_nxt;

  logic [FW-1:0] free_now;
  logic [FW-1:0] free_after;
  logic [2:0]    status;
  logic          done;
  logic          ram_we;
  logic          read_hit;
  logic          consumed;
  logic [7:0]    ram_rdata;

  function automatic logic [OW-1:0] next_off(input logic [OW-1:0] off);
    next_off = (off == LAST_OFF) ? '0 : off + OW'(1);
  endfunction

  function automatic logic [FW-1:0] free_calc(input logic [OW-1:0] wr,
                                              input logic [OW-1:0] rd);
    if (wr >= rd) begin
      free_calc = DEPTH_F - FW'(1) - {1'b0, wr} + {1'b0, rd};
    end else begin
      free_calc = {1'b0, rd} - {1'b0, wr} - FW'(1);
    end
  endfunction

  assign free_now = free_calc(wr_off_r, rd_off_r);

  always_comb begin
    wr_off_nxt    = wr_off_r;
    rd_off_nxt    = rd_off_r;
    admitted_nxt  = admitted_r;
    trim_drop_nxt = trim_drop_r;
    remaining_nxt = remaining_r;
    accepted_nxt  = accepted_r;
    status        = ST_DROPPED;
    done          = 1'b0;
    ram_we        = 1'b0;
    read_hit      = 1'b0;
    consumed      = 1'b1;
    case (in_data.action)
      ACT_OPEN: begin
        remaining_nxt = in_data.message_length;
        accepted_nxt  = '0;
        trim_drop_nxt = 1'b0;
        if (mode_r == MODE_BLOCK || mode_r == MODE_TRIM) begin
          admitted_nxt = 1'b1;
        end else begin
          admitted_nxt = (32'(free_now) >= 32'(in_data.message_length));
        end
        status = admitted_nxt ? ST_ACCEPTED : ST_DROPPED;
        done   = (in_data.message_length == 16'd0);
      end
      ACT_DATA: begin
        if (remaining_r != 16'd0) begin
          if (!admitted_r || trim_drop_r) begin
            status = ST_DROPPED;
          end else if (free_now == '0) begin
            if (mode_r == MODE_BLOCK) begin
              status   = ST_RETRY;
              consumed = 1'b0;
            end else begin
              trim_drop_nxt = 1'b1;
              status        = ST_DROPPED;
            end
          end else begin
            ram_we       = 1'b1;
            wr_off_nxt   = next_off(wr_off_r);
            accepted_nxt = accepted_r + 16'd1;
            status       = ST_ACCEPTED;
          end
          if (consumed) begin
            remaining_nxt = remaining_r - 16'd1;
            done          = (remaining_r == 16'd1);
          end
        end
      end
      ACT_READ: begin
        if (rd_off_r == wr_off_r) begin
          status = ST_EMPTY;
        end else begin
          rd_off_nxt = next_off(rd_off_r);
          status     = ST_READ;
          read_hit   = 1'b1;
        end
      end
      default: begin
        status = ST_DROPPED;
      end
    endcase
  end

  assign free_after   = free_calc(wr_off_nxt, rd_off_nxt);
  assign sts.read_hit = read_hit;

  always_comb begin
    out_nxt                = out_r;
    out_nxt.status         = status;
    out_nxt.read_byte      = 8'd0;
    out_nxt.free_space     = 10'(free_after);
    out_nxt.accepted_count = accepted_nxt;
    out_nxt.message_done   = done;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SKIP;
      wr_off_r    <= '0;
      rd_off_r    <= '0;
      admitted_r  <= 1'b0;
      trim_drop_r <= 1'b0;
      remaining_r <= '0;
      accepted_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (cmd.step) begin
        wr_off_r    <= wr_off_nxt;
        rd_off_r    <= rd_off_nxt;
        admitted_r  <= admitted_nxt;
        trim_drop_r <= trim_drop_nxt;
        remaining_r <= remaining_nxt;
        accepted_r  <= accepted_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_r <= out_nxt;
    end else if (cmd.load_read) begin
      out_r.read_byte <= ram_rdata;
    end
  end

  assign out_data = out_r;

  rfom_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.step && ram_we),
    .wr_addr (wr_off_r),
    .wr_data (in_data.data_byte),
    .rd_addr (rd_off_r),
    .rd_data (ram_rdata)
  );

  a_wr_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wr_off_r) < BUFFER_DEPTH)
    else $error("write offset out of range");

  a_rd_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rd_off_r) < BUFFER_DEPTH)
    else $error("read offset out of range");

  a_store_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && read_hit) |=> (free_now != '0))
    else $error("read of a byte left no free slot");

endmodule

// ----- src/rfom_ctrl.sv -----
// rfom_ctrl: handshake controller, sequences the registered store read
// depends on rfom_pkg
module rfom_ctrl import rfom_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  rfom_sts_t sts,
  output rfom_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_RD
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready      = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign cmd.step      = in_valid && in_ready;
  assign cmd.load_read = (state_r == S_RD);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.step && sts.read_hit) begin
            state_r     <= S_RD;
            out_valid_r <= 1'b0;
          end else if (cmd.step) begin
            out_valid_r <= 1'b1;
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_RD: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  a_rd_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> !out_valid_r)
    else $error("result register busy while store read in flight");

  a_read_hit_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.read_hit) |=> (state_r == S_RD))
    else $error("read beat did not start store read");

  a_rd_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (state_r == S_IDLE && out_valid_r))
    else $error("store read did not complete in one cycle");

endmodule
